// ----- design/prq_pkg.sv -----
// ----------------------------------------------------------------------------
// prq_pkg: shared types and constants of the priority ready queue scheduler
// Holds the command and status codes, reset values, sequencer states, queue
// cell controls and the item structs of the command and result channels.
// ----------------------------------------------------------------------------
package prq_pkg;

  // command codes
  typedef enum logic [2:0] {
    CMD_MAKE_READY = 3'd0,
    CMD_YIELD      = 3'd1,
    CMD_BLOCK      = 3'd2,
    CMD_SLEEP      = 3'd3,
    CMD_TICK       = 3'd4,
    CMD_SET_PRIO   = 3'd5
  } cmd_t;

  // result status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_READY_FULL  = 2'd1;
  localparam logic [1:0] ST_SLEEP_FULL  = 2'd2;
  localparam logic [1:0] ST_SLEEP_IDLE  = 2'd3;

  // fixed reset values
  localparam int         DEFAULT_PRIORITY = 31;
  localparam logic [7:0] SLICE_RESET      = 8'd4;
  localparam logic [7:0] SLICE_MAX        = 8'hFF;
  localparam logic [15:0] INITIAL_ID      = 16'd1;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_YIELD,
    S_YIELD_INS,
    S_LEAVE,
    S_WAKE,
    S_TICK_END
  } state_t;

  // per-cycle operation on a queue row
  typedef struct packed {
    logic ins;
    logic pop;
  } q_op_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] thread_id;
    logic [5:0]  priority_req;
    logic [62:0] tick_value;
  } in_t;

  typedef struct packed {
    logic [15:0] running_id;
    logic [5:0]  running_priority;
    logic        idle_active;
    logic        switched;
    logic [4:0]  ready_count;
    logic [1:0]  status;
  } out_t;

endpackage

// ----- design/priority_ready_queue_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler_top: hardware thread scheduler
// Ready queue by priority, sleep queue by wake tick, running thread and
// time slice, driven by a small command sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   A command item is taken at a rising edge with start high and busy low.
//   busy stays high while the sequencer works the command. Exactly one
//   result item follows, shown on out_item for one cycle with out_valid
//   high; the receiver cannot stall it. The result may overlap the cycle in
//   which the next command is taken.
//   Rejected and no-op commands answer straight from idle. Make ready and
//   set priority pass the check state, yield the yield state, block and
//   sleep the leave state; a check may go on to a yield, and a yield that
//   swaps threads reinserts the old one. A timer tick runs the wake sweep,
//   which moves one sleeper per cycle, then the tick end state, which may
//   yield. Inserts and head pops act on the whole cell row at once.
//   cfg_we writes slice_length (reset 4); write it only while not busy.
//   After reset thread 1 runs at priority 31, both queues are empty and the
//   block is ready at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module priority_ready_queue_scheduler_top #(
  parameter int READY_DEPTH  = 16,
  parameter int SLEEP_DEPTH  = 16,
  parameter int PRIORITY_MAX = 63
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  prq_pkg::in_t  in_item,
  output logic          out_valid,
  output prq_pkg::out_t out_item,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_wdata
);

  localparam int RFW = $clog2(READY_DEPTH + 1);
  localparam int SFW = $clog2(SLEEP_DEPTH + 1);
  localparam logic [5:0] PMAX6 = 6'(PRIORITY_MAX);
  localparam logic [5:0] PRIO_RESET =
    (prq_pkg::DEFAULT_PRIORITY > PRIORITY_MAX) ? PMAX6 : 6'(prq_pkg::DEFAULT_PRIORITY);

  prq_pkg::state_t state_r, state_nxt;
  logic [15:0] cur_id_r, cur_id_nxt;
  logic [5:0]  cur_pri_r, cur_pri_nxt;
  logic        cur_idle_r, cur_idle_nxt;
  logic [7:0]  slice_cnt_r, slice_cnt_nxt;
  logic [7:0]  slice_len_r;
  logic [1:0]  status_r, status_nxt;
  logic        sw_r, sw_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] tid_r, tid_nxt;
  logic [5:0]  pri_r, pri_nxt;
  logic [62:0] tick_r, tick_nxt;

  prq_pkg::q_op_t rq_op, sq_op;
  logic [5:0]     rq_new_key, rq_head_key;
  logic [15:0]    rq_new_data, rq_head_data;
  logic [RFW-1:0] rq_fill;
  logic           rq_full;
  logic [62:0]    sq_head_key;
  logic [21:0]    sq_head_data;
  logic [SFW-1:0] sq_fill;
  logic           sq_full;

  logic [5:0]  in_pri;
  logic        preempt;
  logic        rq_any;
  logic [7:0]  slice_inc;

  // ready queue: priority key, highest first
  prq_queue #(.DEPTH(READY_DEPTH), .KW(6), .DW(16), .ORDER_ASC(1'b0)) u_ready (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (rq_op),
    .new_key   (rq_new_key),
    .new_data  (rq_new_data),
    .head_key  (rq_head_key),
    .head_data (rq_head_data),
    .fill      (rq_fill),
    .full      (rq_full)
  );

  // sleep queue: wake tick key, earliest first; insert happens on accept
  prq_queue #(.DEPTH(SLEEP_DEPTH), .KW(63), .DW(22), .ORDER_ASC(1'b1)) u_sleep (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (sq_op),
    .new_key   (in_item.tick_value),
    .new_data  ({cur_id_r, cur_pri_r}),
    .head_key  (sq_head_key),
    .head_data (sq_head_data),
    .fill      (sq_fill),
    .full      (sq_full)
  );

  // clamped request priority and preemption test
  assign in_pri    = (32'(in_item.priority_req) > PRIORITY_MAX) ? PMAX6 : in_item.priority_req;
  assign rq_any    = (rq_fill != '0);
  assign preempt   = !cur_idle_r && rq_any && (cur_pri_r < rq_head_key);
  assign slice_inc = (slice_cnt_r == prq_pkg::SLICE_MAX) ? slice_cnt_r : slice_cnt_r + 8'd1;

  // command sequencer
  always_comb begin
    state_nxt     = state_r;
    cur_id_nxt    = cur_id_r;
    cur_pri_nxt   = cur_pri_r;
    cur_idle_nxt  = cur_idle_r;
    slice_cnt_nxt = slice_cnt_r;
    status_nxt    = status_r;
    sw_nxt        = sw_r;
    out_valid_nxt = 1'b0;
    tid_nxt       = tid_r;
    pri_nxt       = pri_r;
    tick_nxt      = tick_r;
    rq_op         = '0;
    sq_op         = '0;
    rq_new_key    = pri_r;
    rq_new_data   = tid_r;
    case (state_r)
      prq_pkg::S_IDLE: begin
        if (start) begin
          status_nxt = prq_pkg::ST_OK;
          sw_nxt     = 1'b0;
          tick_nxt   = in_item.tick_value;
          state_nxt  = prq_pkg::S_IDLE;
          case (in_item.command)
            prq_pkg::CMD_MAKE_READY: begin
              if (rq_full) begin
                status_nxt    = prq_pkg::ST_READY_FULL;
                out_valid_nxt = 1'b1;
              end else begin
                rq_op.ins   = 1'b1;
                rq_new_key  = in_pri;
                rq_new_data = in_item.thread_id;
                state_nxt   = prq_pkg::S_CHECK;
              end
            end
            prq_pkg::CMD_YIELD: state_nxt = prq_pkg::S_YIELD;
            prq_pkg::CMD_BLOCK: state_nxt = prq_pkg::S_LEAVE;
            prq_pkg::CMD_SLEEP: begin
              if (cur_idle_r) begin
                status_nxt    = prq_pkg::ST_SLEEP_IDLE;
                out_valid_nxt = 1'b1;
              end else if (sq_full) begin
                status_nxt    = prq_pkg::ST_SLEEP_FULL;
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = prq_pkg::S_LEAVE;
                sq_op.ins = 1'b1;
              end
            end
            prq_pkg::CMD_TICK: state_nxt = prq_pkg::S_WAKE;
            prq_pkg::CMD_SET_PRIO: begin
              if (!cur_idle_r) begin
                cur_pri_nxt = in_pri;
                state_nxt   = prq_pkg::S_CHECK;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: out_valid_nxt = 1'b1;
          endcase
        end
      end
      prq_pkg::S_CHECK: begin
        if (preempt) begin
          state_nxt = prq_pkg::S_YIELD;
        end else begin
          state_nxt     = prq_pkg::S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      prq_pkg::S_YIELD: begin
        slice_cnt_nxt = '0;
        state_nxt     = prq_pkg::S_IDLE;
        out_valid_nxt = 1'b1;
        if (rq_any && (cur_idle_r || cur_pri_r <= rq_head_key)) begin
          rq_op.pop    = 1'b1;
          cur_id_nxt   = rq_head_data;
          cur_pri_nxt  = rq_head_key;
          cur_idle_nxt = 1'b0;
          sw_nxt       = 1'b1;
          if (!cur_idle_r) begin
            tid_nxt       = cur_id_r;
            pri_nxt       = cur_pri_r;
            state_nxt     = prq_pkg::S_YIELD_INS;
            out_valid_nxt = 1'b0;
          end
        end
      end
      prq_pkg::S_YIELD_INS: begin
        // old thread goes back behind its equals
        rq_op.ins     = 1'b1;
        state_nxt     = prq_pkg::S_IDLE;
        out_valid_nxt = 1'b1;
      end
      prq_pkg::S_LEAVE: begin
        slice_cnt_nxt = '0;
        state_nxt     = prq_pkg::S_IDLE;
        out_valid_nxt = 1'b1;
        if (rq_any) begin
          rq_op.pop    = 1'b1;
          cur_id_nxt   = rq_head_data;
          cur_pri_nxt  = rq_head_key;
          cur_idle_nxt = 1'b0;
          sw_nxt       = 1'b1;
        end else begin
          sw_nxt       = !cur_idle_r;
          cur_id_nxt   = '0;
          cur_pri_nxt  = '0;
          cur_idle_nxt = 1'b1;
        end
      end
      prq_pkg::S_WAKE: begin
        // one due sleeper moves per cycle
        if (sq_fill != '0 && sq_head_key <= tick_r) begin
          if (rq_full) begin
            status_nxt = prq_pkg::ST_READY_FULL;
            state_nxt  = prq_pkg::S_TICK_END;
          end else begin
            rq_op.ins   = 1'b1;
            sq_op.pop   = 1'b1;
            rq_new_key  = sq_head_data[5:0];
            rq_new_data = sq_head_data[21:6];
          end
        end else begin
          state_nxt = prq_pkg::S_TICK_END;
        end
      end
      prq_pkg::S_TICK_END: begin
        if (slice_inc >= slice_len_r || preempt) begin
          state_nxt = prq_pkg::S_YIELD;
        end else begin
          slice_cnt_nxt = slice_inc;
          state_nxt     = prq_pkg::S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = prq_pkg::S_IDLE;
    endcase
  end

  // control and running thread registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= prq_pkg::S_IDLE;
      cur_id_r    <= prq_pkg::INITIAL_ID;
      cur_pri_r   <= PRIO_RESET;
      cur_idle_r  <= 1'b0;
      slice_cnt_r <= '0;
      slice_len_r <= prq_pkg::SLICE_RESET;
      status_r    <= prq_pkg::ST_OK;
      sw_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_id_r    <= cur_id_nxt;
      cur_pri_r   <= cur_pri_nxt;
      cur_idle_r  <= cur_idle_nxt;
      slice_cnt_r <= slice_cnt_nxt;
      status_r    <= status_nxt;
      sw_r        <= sw_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        slice_len_r <= cfg_wdata;
      end
    end
  end

  // command payload registers
  always_ff @(posedge clk) begin
    tid_r  <= tid_nxt;
    pri_r  <= pri_nxt;
    tick_r <= tick_nxt;
  end

  // result item
  assign busy                      = (state_r != prq_pkg::S_IDLE);
  assign out_valid                 = out_valid_r;
  assign out_item.running_id       = cur_id_r;
  assign out_item.running_priority = cur_pri_r;
  assign out_item.idle_active      = cur_idle_r;
  assign out_item.switched         = sw_r;
  assign out_item.ready_count      = 5'(rq_fill);
  assign out_item.status           = status_r;

`ifndef ASSERT_OFF
  // a result never shows while a command is in progress
  a_out_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result strobe while busy");

  // ready fill never passes the depth
  a_ready_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(rq_fill) <= READY_DEPTH) else $error("ready queue overrun");

  // sleep fill never passes the depth
  a_sleep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(sq_fill) <= SLEEP_DEPTH) else $error("sleep queue overrun");

  // idle thread always reports id zero
  a_idle_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.idle_active) |-> (out_item.running_id == 16'd0))
    else $error("idle with nonzero id");
`endif

endmodule

// ----- design/prq_cell.sv -----
// ----------------------------------------------------------------------------
// prq_cell: one entry of a sorted queue row
// Holds a key and data word; on insert it keeps, takes the new entry or
// takes its left neighbor; on pop it takes its right neighbor.
// ----------------------------------------------------------------------------
module prq_cell #(
  parameter int KW        = 6,
  parameter int DW        = 16,
  parameter bit ORDER_ASC = 1'b0
) (
  input  logic            clk,
  input  prq_pkg::q_op_t  op,
  input  logic            at_or_past_fill,
  input  logic            left_ins,
  input  logic [KW-1:0]   new_key,
  input  logic [DW-1:0]   new_data,
  input  logic [KW-1:0]   left_key,
  input  logic [DW-1:0]   left_data,
  input  logic [KW-1:0]   right_key,
  input  logic [DW-1:0]   right_data,
  output logic [KW-1:0]   key,
  output logic [DW-1:0]   data,
  output logic            ins_here
);

  logic [KW-1:0] key_r, key_nxt;
  logic [DW-1:0] data_r, data_nxt;
  logic          behind;

  // new entry goes ahead of this one when it orders strictly first
  assign behind   = ORDER_ASC ? (key_r > new_key) : (key_r < new_key);
  assign ins_here = at_or_past_fill || behind;

  // next entry from own, new, left or right
  always_comb begin
    key_nxt  = key_r;
    data_nxt = data_r;
    if (op.ins && ins_here) begin
      if (left_ins) begin
        key_nxt  = left_key;
        data_nxt = left_data;
      end else begin
        key_nxt  = new_key;
        data_nxt = new_data;
      end
    end else if (op.pop) begin
      key_nxt  = right_key;
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    data_r <= data_nxt;
  end

  assign key  = key_r;
  assign data = data_r;

endmodule

// ----- design/prq_queue.sv -----
// ----------------------------------------------------------------------------
// prq_queue: sorted queue built as a row of cells
// Ordered insert and head pop act on all cells at once; a fill count marks the
// entries in use.
// ----------------------------------------------------------------------------
module prq_queue #(
  parameter int DEPTH     = 16,
  parameter int KW        = 6,
  parameter int DW        = 16,
  parameter bit ORDER_ASC = 1'b0,
  localparam int FW       = $clog2(DEPTH + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  prq_pkg::q_op_t  op,
  input  logic [KW-1:0]   new_key,
  input  logic [DW-1:0]   new_data,
  output logic [KW-1:0]   head_key,
  output logic [DW-1:0]   head_data,
  output logic [FW-1:0]   fill,
  output logic            full
);

  logic [KW-1:0] keys  [DEPTH];
  logic [DW-1:0] datas [DEPTH];
  logic          ins_f [DEPTH];
  logic [FW-1:0] fill_r, fill_nxt;

  // row of cells, each linked to its neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int L = (i == 0) ? 0 : i - 1;
    localparam int R = (i == DEPTH - 1) ? i : i + 1;
    prq_cell #(.KW(KW), .DW(DW), .ORDER_ASC(ORDER_ASC)) u_cell (
      .clk             (clk),
      .op              (op),
      .at_or_past_fill (32'(fill_r) <= i),
      .left_ins        ((i == 0) ? 1'b0 : ins_f[L]),
      .new_key         (new_key),
      .new_data        (new_data),
      .left_key        (keys[L]),
      .left_data       (datas[L]),
      .right_key       (keys[R]),
      .right_data      (datas[R]),
      .key             (keys[i]),
      .data            (datas[i]),
      .ins_here        (ins_f[i])
    );
  end

  // fill count
  always_comb begin
    fill_nxt = fill_r;
    if (op.ins && !op.pop) begin
      fill_nxt = fill_r + FW'(1);
    end else if (op.pop && !op.ins) begin
      fill_nxt = fill_r - FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  assign head_key  = keys[0];
  assign head_data = datas[0];
  assign fill      = fill_r;
  assign full      = (32'(fill_r) >= DEPTH);

endmodule

// ----- tb/priority_ready_queue_scheduler_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler_top_tb: self-checking bench of the scheduler
// A driver sends command items in random bursts from a pending queue, and a
// scheduler model predicts each result. A monitor compares every result
// field by field with the oldest prediction. Slice length changes between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module priority_ready_queue_scheduler_top_tb;

  localparam int QDEPTH = 16;
  localparam int PMAX = 63;
  localparam int MAX_CYCLES = 1000000;
  // command codes with no function
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  prq_pkg::in_t in_item;
  logic out_valid;
  prq_pkg::out_t out_item;
  logic cfg_we;
  logic [7:0] cfg_wdata;

  priority_ready_queue_scheduler_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // scheduler model state
  logic [15:0] rq_id [QDEPTH];
  logic [5:0] rq_prio [QDEPTH];
  int rq_fill;
  logic [15:0] sq_id [QDEPTH];
  logic [5:0] sq_prio [QDEPTH];
  logic [62:0] sq_wake [QDEPTH];
  int sq_fill;
  logic [15:0] cur_id;
  logic [5:0] cur_prio;
  logic cur_idle;
  int slice_cnt;
  int slice_len;

  prq_pkg::in_t pending_cmds[$];
  prq_pkg::out_t expected_results[$];
  int errors;
  int cycles;
  int gap_left;
  int burst_left;
  int hold_off;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // cycle counter with timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic bit rq_insert(logic [15:0] id, logic [5:0] p);
    int pos;
    if (rq_fill >= QDEPTH) return 1'b0;
    pos = rq_fill;
    while (pos > 0 && rq_prio[pos-1] < p) begin
      rq_id[pos] = rq_id[pos-1];
      rq_prio[pos] = rq_prio[pos-1];
      pos--;
    end
    rq_id[pos] = id;
    rq_prio[pos] = p;
    rq_fill++;
    return 1'b1;
  endfunction

  function automatic void run_head_thread();
    cur_id = rq_id[0];
    cur_prio = rq_prio[0];
    cur_idle = 1'b0;
    rq_fill--;
    for (int i = 0; i < rq_fill; i++) begin
      rq_id[i] = rq_id[i+1];
      rq_prio[i] = rq_prio[i+1];
    end
  endfunction

  function automatic bit preempt_pending();
    return !cur_idle && rq_fill > 0 && cur_prio < rq_prio[0];
  endfunction

  function automatic bit yield_thread();
    logic [15:0] oid;
    logic [5:0] op;
    bit sw;
    sw = 1'b0;
    if (cur_idle) begin
      if (rq_fill > 0) begin
        run_head_thread();
        sw = 1'b1;
      end
    end else if (rq_fill > 0 && cur_prio <= rq_prio[0]) begin
      oid = cur_id;
      op = cur_prio;
      run_head_thread();
      void'(rq_insert(oid, op));
      sw = 1'b1;
    end
    slice_cnt = 0;
    return sw;
  endfunction

  function automatic bit leave_thread();
    bit sw;
    if (rq_fill > 0) begin
      run_head_thread();
      sw = 1'b1;
    end else begin
      sw = !cur_idle;
      cur_id = '0;
      cur_prio = '0;
      cur_idle = 1'b1;
    end
    slice_cnt = 0;
    return sw;
  endfunction

  function automatic void sq_insert(logic [15:0] id, logic [5:0] p, logic [62:0] w);
    int pos;
    pos = sq_fill;
    while (pos > 0 && sq_wake[pos-1] > w) begin
      sq_id[pos] = sq_id[pos-1];
      sq_prio[pos] = sq_prio[pos-1];
      sq_wake[pos] = sq_wake[pos-1];
      pos--;
    end
    sq_id[pos] = id;
    sq_prio[pos] = p;
    sq_wake[pos] = w;
    sq_fill++;
  endfunction

  function automatic void sq_drop_head();
    sq_fill--;
    for (int i = 0; i < sq_fill; i++) begin
      sq_id[i] = sq_id[i+1];
      sq_prio[i] = sq_prio[i+1];
      sq_wake[i] = sq_wake[i+1];
    end
  endfunction

  // predicted scheduler result for one command item
  function automatic prq_pkg::out_t schedule_cmd(prq_pkg::in_t it);
    prq_pkg::out_t r;
    logic [1:0] st;
    bit sw;
    logic [5:0] p;
    st = prq_pkg::ST_OK;
    sw = 1'b0;
    p = (it.priority_req > PMAX) ? 6'(PMAX) : it.priority_req;
    case (it.command)
      prq_pkg::CMD_MAKE_READY: begin
        if (!rq_insert(it.thread_id, p)) st = prq_pkg::ST_READY_FULL;
        else if (preempt_pending()) sw = yield_thread();
      end
      prq_pkg::CMD_YIELD: sw = yield_thread();
      prq_pkg::CMD_BLOCK: sw = leave_thread();
      prq_pkg::CMD_SLEEP: begin
        if (cur_idle) st = prq_pkg::ST_SLEEP_IDLE;
        else if (sq_fill >= QDEPTH) st = prq_pkg::ST_SLEEP_FULL;
        else begin
          sq_insert(cur_id, cur_prio, it.tick_value);
          sw = leave_thread();
        end
      end
      prq_pkg::CMD_TICK: begin
        while (sq_fill > 0 && sq_wake[0] <= it.tick_value) begin
          if (!rq_insert(sq_id[0], sq_prio[0])) begin
            st = prq_pkg::ST_READY_FULL;
            break;
          end
          sq_drop_head();
        end
        if (slice_cnt < 255) slice_cnt++;
        if (slice_cnt >= slice_len || preempt_pending()) sw = yield_thread();
      end
      prq_pkg::CMD_SET_PRIO: begin
        if (!cur_idle) begin
          cur_prio = p;
          if (preempt_pending()) sw = yield_thread();
        end
      end
      default: ;
    endcase
    r.running_id = cur_id;
    r.running_priority = cur_prio;
    r.idle_active = cur_idle;
    r.switched = sw;
    r.ready_count = 5'(rq_fill);
    r.status = st;
    return r;
  endfunction

  // driver: bursts and gaps, predicts on accept
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
      burst_left <= 0;
    end else if (start && !busy) begin
      expected_results.push_back(schedule_cmd(in_item));
      if (burst_left > 0 && pending_cmds.size() > 0 && hold_off == 0) begin
        in_item <= pending_cmds.pop_front();
        burst_left <= burst_left - 1;
      end else begin
        start <= 1'b0;
        gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
      end
    end else if (!start) begin
      if (gap_left > 0) gap_left <= gap_left - 1;
      else if (pending_cmds.size() > 0 && hold_off == 0) begin
        in_item <= pending_cmds.pop_front();
        start <= 1'b1;
        burst_left <= $urandom_range(0, 30);
      end
    end
  end

  // monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    prq_pkg::out_t e;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("result with no prediction waiting");
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_item.running_id !== e.running_id) begin
          $error("running_id exp %0d act %0d", e.running_id, out_item.running_id);
          errors++;
        end
        if (out_item.running_priority !== e.running_priority) begin
          $error("running_priority exp %0d act %0d", e.running_priority,
                 out_item.running_priority);
          errors++;
        end
        if (out_item.idle_active !== e.idle_active) begin
          $error("idle_active exp %0d act %0d", e.idle_active, out_item.idle_active);
          errors++;
        end
        if (out_item.switched !== e.switched) begin
          $error("switched exp %0d act %0d", e.switched, out_item.switched);
          errors++;
        end
        if (out_item.ready_count !== e.ready_count) begin
          $error("ready_count exp %0d act %0d", e.ready_count, out_item.ready_count);
          errors++;
        end
        if (out_item.status !== e.status) begin
          $error("status exp %0d act %0d", e.status, out_item.status);
          errors++;
        end
      end
    end
  end

  function automatic prq_pkg::in_t make_cmd(logic [2:0] c, logic [15:0] id, logic [5:0] p,
                                            logic [62:0] t);
    prq_pkg::in_t it;
    it.command = c;
    it.thread_id = id;
    it.priority_req = p;
    it.tick_value = t;
    return it;
  endfunction

  // random item, mostly legal codes with a running tick
  function automatic prq_pkg::in_t rand_cmd(ref logic [62:0] now);
    int k;
    logic [62:0] t;
    k = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) t = 63'({$urandom, $urandom});
    else t = now + 63'($urandom_range(0, 12));
    if (k < 28) return make_cmd(prq_pkg::CMD_MAKE_READY, 16'($urandom), 6'($urandom), t);
    if (k < 38) return make_cmd(prq_pkg::CMD_YIELD, 16'($urandom), 6'($urandom), t);
    if (k < 48) return make_cmd(prq_pkg::CMD_BLOCK, 16'($urandom), 6'($urandom), t);
    if (k < 62) return make_cmd(prq_pkg::CMD_SLEEP, 16'($urandom), 6'($urandom), t);
    if (k < 88) begin
      now = now + 63'($urandom_range(0, 4));
      return make_cmd(prq_pkg::CMD_TICK, 16'($urandom), 6'($urandom), now);
    end
    if (k < 97) return make_cmd(prq_pkg::CMD_SET_PRIO, 16'($urandom), 6'($urandom), t);
    if (k < 98) return make_cmd(CMD_SPARE_LO, 16'($urandom), 6'($urandom), t);
    return make_cmd(CMD_SPARE_HI, 16'($urandom), 6'($urandom), t);
  endfunction

  // wait until the block has drained, then a further settling wait
  task automatic drain();
    while (pending_cmds.size() > 0 || start || busy || expected_results.size() > 0)
      @(posedge clk);
    repeat (QDEPTH + 8) @(posedge clk);
  endtask

  task automatic write_slice(logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    slice_len = v;
  endtask

  initial begin
    logic [62:0] now;
    logic [7:0] slice_set [5];
    errors = 0;
    cycles = 0;
    hold_off = 0;
    rst_n = 1'b0;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_item = '0;
    rq_fill = 0;
    sq_fill = 0;
    cur_id = prq_pkg::INITIAL_ID;
    cur_prio = 6'(prq_pkg::DEFAULT_PRIORITY);
    cur_idle = 1'b0;
    slice_cnt = 0;
    slice_len = prq_pkg::SLICE_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, idle cases, a full ready queue, top priority, unused codes
    pending_cmds.push_back(make_cmd(prq_pkg::CMD_SET_PRIO, 16'd0, 6'h3F, '0));
    pending_cmds.push_back(make_cmd(prq_pkg::CMD_MAKE_READY, 16'hFFFF, 6'h3F, '0));
    pending_cmds.push_back(make_cmd(prq_pkg::CMD_MAKE_READY, 16'h0000, 6'h00, '1));
    pending_cmds.push_back(make_cmd(prq_pkg::CMD_YIELD, 16'd0, 6'd0, 63'd0));
    pending_cmds.push_back(make_cmd(prq_pkg::CMD_SLEEP, 16'd0, 6'd0, 63'h7FFFFFFFFFFFFFFF));
    pending_cmds.push_back(make_cmd(prq_pkg::CMD_BLOCK, 16'd0, 6'd0, 63'd0));
    pending_cmds.push_back(make_cmd(prq_pkg::CMD_BLOCK, 16'd0, 6'd0, 63'd0));
    pending_cmds.push_back(make_cmd(prq_pkg::CMD_BLOCK, 16'd0, 6'd0, 63'd0));
    pending_cmds.push_back(make_cmd(prq_pkg::CMD_SLEEP, 16'd0, 6'd0, 63'd5));
    pending_cmds.push_back(make_cmd(prq_pkg::CMD_SET_PRIO, 16'd0, 6'h20, 63'd0));
    pending_cmds.push_back(make_cmd(prq_pkg::CMD_TICK, 16'd0, 6'd0, 63'd3));
    pending_cmds.push_back(make_cmd(CMD_SPARE_LO, 16'h1234, 6'h15, 63'h2A));
    pending_cmds.push_back(make_cmd(CMD_SPARE_HI, 16'hABCD, 6'h2A, 63'h55));
    for (int i = 0; i < 18; i++)
      pending_cmds.push_back(make_cmd(prq_pkg::CMD_MAKE_READY, 16'(i + 2), 6'(i % 3),
                                      63'd0));
    pending_cmds.push_back(make_cmd(prq_pkg::CMD_TICK, 16'd0, 6'd0, 63'h7FFFFFFFFFFFFFFF));
    drain();

    // random phases across slice settings
    slice_set = '{8'd1, 8'd255, 8'd4, 8'd2, 8'd7};
    now = '0;
    foreach (slice_set[ph]) begin
      write_slice(slice_set[ph]);
      for (int i = 0; i < 340; i++) pending_cmds.push_back(rand_cmd(now));
      // hold the sender once until everything has come back
      if (ph == 2) begin
        while (pending_cmds.size() > 170) @(posedge clk);
        hold_off = 1;
        while (start || busy || expected_results.size() > 0) @(posedge clk);
        hold_off = 0;
      end
      drain();
    end

    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
